@@ hw/rtl/nps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types and constants for the nearest preceding symbol search core.
// ----------------------------------------------------------------------------
package nps_pkg;

    localparam int VALUE_W = 32;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;

    // Input action codes.
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_BASE_ADDRESS = 1'b0;
    localparam logic CFG_SYMBOL_COUNT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // Controller to scan pipeline.
    typedef struct packed {
        logic start;
        logic issue;
    } t_scan_ctrl;

    // Scan pipeline to controller.
    typedef struct packed {
        logic busy;
        logic stop;
    } t_scan_stat;

endpackage

@@ hw/rtl/nps_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_table
// Symbol table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module nps_table
    import nps_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int AW          = 10
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [VALUE_W-1:0] i_wr_value,
    input  logic               i_wr_named,
    input  logic               i_rd_en,
    input  logic [AW-1:0]      i_rd_addr,
    output logic [VALUE_W-1:0] o_rd_value,
    output logic               o_rd_named
);

    logic [VALUE_W:0] r_mem [TABLE_DEPTH];
    logic [VALUE_W:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_named, i_wr_value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_value = r_rdata[VALUE_W-1:0];
    assign o_rd_named = r_rdata[VALUE_W];

endmodule

@@ hw/rtl/nps_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_scan
// Scan pipeline: relocate, subtract, then keep the nearest preceding entry.
// ----------------------------------------------------------------------------
module nps_scan
    import nps_pkg::*;
#(
    parameter int AW = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_scan_ctrl         i_ctrl,
    input  logic [AW-1:0]      i_rd_addr,
    input  logic [VALUE_W-1:0] i_query_address,
    input  logic [VALUE_W-1:0] i_base_address,
    input  logic [VALUE_W-1:0] i_rd_value,
    input  logic               i_rd_named,
    output t_scan_stat         o_stat,
    output logic               o_found,
    output logic [AW-1:0]      o_best,
    output logic [VALUE_W-1:0] o_dist
);

    // Stage valids and the entry index that travels with each stage.
    logic               r_v1, r_v2, r_v3;
    logic [AW-1:0]      r_idx1, r_idx2, r_idx3;
    logic [VALUE_W-1:0] r_reloc;
    logic               r_named2;
    logic [VALUE_W-1:0] r_d;
    logic               r_cand3;
    logic [VALUE_W-1:0] r_addr;
    logic [VALUE_W-1:0] r_dist;
    logic [AW-1:0]      r_best;
    logic               r_found;
    logic               r_stop;

    logic [VALUE_W:0]   diff;

    assign diff = {1'b0, r_addr} - {1'b0, r_reloc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_ctrl.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx1   <= i_rd_addr;
        r_idx2   <= r_idx1;
        r_reloc  <= i_rd_value + i_base_address;
        r_named2 <= i_rd_named;
        r_idx3   <= r_idx2;
        r_d      <= diff[VALUE_W-1:0];
        // A borrow means the relocated value lies above the address.
        r_cand3  <= r_named2 && !diff[VALUE_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_stop  <= 1'b0;
        end else if (i_ctrl.start) begin
            r_found <= 1'b0;
            r_stop  <= 1'b0;
        end else if (r_v3 && r_cand3 && !r_stop) begin
            if (r_d < r_dist) begin
                r_found <= 1'b1;
                r_stop  <= (r_d == '0);
            end else if (r_d == r_dist) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_addr <= i_query_address;
            r_dist <= i_query_address;
            r_best <= '0;
        end else if (r_v3 && r_cand3 && !r_stop) begin
            if (r_d < r_dist) begin
                r_dist <= r_d;
                r_best <= r_idx3;
            end else if (r_d == r_dist) begin
                // A later entry at the same distance wins the tie.
                r_best <= r_idx3;
            end
        end
    end

    assign o_stat.busy = r_v1 || r_v2 || r_v3;
    assign o_stat.stop = r_stop;
    assign o_found     = r_found;
    assign o_best      = r_best;
    assign o_dist      = r_dist;

endmodule

@@ hw/rtl/nps_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_ctrl
// Sequencer: takes transactions, steps the scan address, hands off results.
// ----------------------------------------------------------------------------
module nps_ctrl
    import nps_pkg::*;
#(
    parameter int AW = 10,
    parameter int CW = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_action,
    input  logic [CW-1:0] i_limit,
    input  t_scan_stat    i_stat,
    input  logic          i_out_free,
    output t_scan_ctrl    o_ctrl,
    output logic [AW-1:0] o_rd_addr,
    output logic          o_in_stall,
    output logic          o_out_load
);

    t_state        r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] idx_inc;
    logic          start;
    logic          issue;

    assign idx_inc = r_idx + 1'b1;
    assign start   = i_accept && (i_action == ACT_QUERY);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = (i_limit == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_stat.stop || (issue && (idx_inc == i_limit))) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_stat.busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        issue      = 1'b0;
        o_out_load = 1'b0;
        unique case (r_state)
            ST_IDLE:  o_in_stall = 1'b0;
            ST_SCAN:  issue      = !i_stat.stop;
            ST_DRAIN: o_in_stall = 1'b1;
            ST_DONE:  o_out_load = i_out_free;
            default:  o_in_stall = 1'b1;
        endcase
    end

    always_comb begin
        n_idx = r_idx;
        if (start) begin
            n_idx = '0;
        end else if (issue) begin
            n_idx = idx_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_ctrl.start = start;
    assign o_ctrl.issue = issue;
    assign o_rd_addr    = r_idx[AW-1:0];

endmodule

@@ hw/rtl/nearest_preceding_symbol_search_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_preceding_symbol_search_core
// Symbol table with a nearest preceding relocated symbol lookup.
// ----------------------------------------------------------------------------
// A write transaction stores one table entry. A query transaction scans
// entries 0 up to min(symbol_count, TABLE_DEPTH)-1 through the one read
// port of the table, one entry per cycle, and finishes once the scan
// pipeline has drained after the last read; an exact hit stops the scan
// early. A query occupies the block until its result is handed to the
// result register, and no new transaction is taken meanwhile. The
// result register lets the next transaction enter while a result waits.
// The table has no reset: every entry covered by symbol_count must be
// written before a query scans it.
// ----------------------------------------------------------------------------
module nearest_preceding_symbol_search_core
    import nps_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration writes.
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [VALUE_W-1:0] i_cfg_data,
    // Input transactions.
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_action,
    input  logic [INDEX_W-1:0] i_entry_index,
    input  logic [VALUE_W-1:0] i_entry_value,
    input  logic               i_entry_named,
    input  logic [VALUE_W-1:0] i_query_address,
    // Result transactions.
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_found,
    output logic [INDEX_W-1:0] o_best_index,
    output logic [VALUE_W-1:0] o_distance
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [VALUE_W-1:0] r_base_address;
    logic [COUNT_W-1:0] r_symbol_count;
    logic               r_out_valid;
    logic               r_found;
    logic [INDEX_W-1:0] r_best_index;
    logic [VALUE_W-1:0] r_distance;

    logic               in_accept;
    logic               out_free;
    logic               out_load;
    logic [31:0]        count32;
    logic [31:0]        limit32;
    logic [CW-1:0]      limit;
    logic [31:0]        slot32;
    logic               wr_en;
    logic [AW-1:0]      rd_addr;
    logic [VALUE_W-1:0] rd_value;
    logic               rd_named;
    t_scan_ctrl         scan_ctrl;
    t_scan_stat         scan_stat;
    logic               scan_found;
    logic [AW-1:0]      scan_best;
    logic [VALUE_W-1:0] scan_dist;
    logic [31:0]        best32;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_address <= '0;
            r_symbol_count <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BASE_ADDRESS: r_base_address <= i_cfg_data;
                CFG_SYMBOL_COUNT: r_symbol_count <= i_cfg_data[COUNT_W-1:0];
                default:          r_base_address <= r_base_address;
            endcase
        end
    end

    // Counts beyond the table are clipped to the table depth.
    assign count32 = 32'(r_symbol_count);
    assign limit32 = (count32 > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : count32;
    assign limit   = limit32[CW-1:0];

    assign in_accept = i_in_valid && !o_in_stall;
    assign slot32    = 32'(i_entry_index);
    assign wr_en     = in_accept && (i_action == ACT_WRITE)
                       && (slot32 < 32'(TABLE_DEPTH));

    nps_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_table (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (slot32[AW-1:0]),
        .i_wr_value (i_entry_value),
        .i_wr_named (i_entry_named),
        .i_rd_en    (scan_ctrl.issue),
        .i_rd_addr  (rd_addr),
        .o_rd_value (rd_value),
        .o_rd_named (rd_named)
    );

    nps_scan #(
        .AW (AW)
    ) u_scan (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (scan_ctrl),
        .i_rd_addr       (rd_addr),
        .i_query_address (i_query_address),
        .i_base_address  (r_base_address),
        .i_rd_value      (rd_value),
        .i_rd_named      (rd_named),
        .o_stat          (scan_stat),
        .o_found         (scan_found),
        .o_best          (scan_best),
        .o_dist          (scan_dist)
    );

    nps_ctrl #(
        .AW (AW),
        .CW (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_action   (i_action),
        .i_limit    (limit),
        .i_stat     (scan_stat),
        .i_out_free (out_free),
        .o_ctrl     (scan_ctrl),
        .o_rd_addr  (rd_addr),
        .o_in_stall (o_in_stall),
        .o_out_load (out_load)
    );

    assign out_free = !r_out_valid || !i_out_stall;
    assign best32   = 32'(scan_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_found      <= scan_found;
            r_best_index <= scan_found ? best32[INDEX_W-1:0] : '0;
            r_distance   <= scan_dist;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_found      = r_found;
    assign o_best_index = r_best_index;
    assign o_distance   = r_distance;

endmodule

@@ hw/rtl/nps_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_checker
// Port-level checks for the nearest preceding symbol search core.
// ----------------------------------------------------------------------------
module nps_checker
    import nps_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               i_action,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic               o_found,
    input logic [INDEX_W-1:0] o_best_index,
    input logic [VALUE_W-1:0] o_distance
);

    // No result is pending right after reset.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // The input is stalled right after a query is accepted.
    a_query_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_action == ACT_QUERY) |=> o_in_stall)
        else $error("input taken right after a query");

    // Without a match the index reads as zero.
    a_no_match_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> (o_best_index == '0))
        else $error("nonzero index without a match");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_found) && $stable(o_best_index) && $stable(o_distance))
        else $error("result changed while stalled");

endmodule

bind nearest_preceding_symbol_search_core nps_checker u_nps_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_action     (i_action),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_found      (o_found),
    .o_best_index (o_best_index),
    .o_distance   (o_distance)
);

@@ sim/nps_check_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_check_pkg
// Transaction types and scoreboard for the symbol search testbench.
// ----------------------------------------------------------------------------
// The scoreboard keeps its own copy of the symbol table and of the two
// registers. It works out the answer to every accepted query and compares
// the results in order of arrival.
// ----------------------------------------------------------------------------
package nps_check_pkg;
    import nps_pkg::*;

    localparam int TB_TABLE_DEPTH = 1024;

    typedef struct packed {
        logic               action;
        logic [INDEX_W-1:0] entry_index;
        logic [VALUE_W-1:0] entry_value;
        logic               entry_named;
        logic [VALUE_W-1:0] query_address;
    } t_lookup_req;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] best_index;
        logic [VALUE_W-1:0] distance;
    } t_lookup_resp;

    class lookup_scoreboard;
        logic [VALUE_W-1:0] sym_value [TB_TABLE_DEPTH];
        logic               sym_named [TB_TABLE_DEPTH];
        logic [VALUE_W-1:0] base_addr;
        logic [COUNT_W-1:0] sym_count;
        t_lookup_resp       expected_lookups [$];
        int                 errors;
        int                 writes_seen;
        int                 queries_seen;
        int                 hits_seen;

        function new();
            for (int i = 0; i < TB_TABLE_DEPTH; i++) begin
                sym_value[i] = '0;
                sym_named[i] = 1'b0;
            end
            base_addr    = '0;
            sym_count    = '0;
            errors       = 0;
            writes_seen  = 0;
            queries_seen = 0;
            hits_seen    = 0;
        endfunction

        function void set_config(input logic idx, input logic [VALUE_W-1:0] data);
            if (idx == CFG_BASE_ADDRESS) begin
                base_addr = data;
            end else begin
                sym_count = data[COUNT_W-1:0];
            end
        endfunction

        // Scan from entry zero. A strictly closer named entry wins and an exact
        // hit ends the scan; a tie hands the choice to the later entry.
        function t_lookup_resp nearest_symbol(input logic [VALUE_W-1:0] addr);
            t_lookup_resp       res;
            int                 limit;
            logic [VALUE_W-1:0] reloc;
            logic [VALUE_W-1:0] gap;
            limit = (sym_count > TB_TABLE_DEPTH) ? TB_TABLE_DEPTH : int'(sym_count);
            res.found      = 1'b0;
            res.best_index = '0;
            res.distance   = addr;
            for (int i = 0; i < limit; i++) begin
                if (!sym_named[i]) continue;
                reloc = sym_value[i] + base_addr;
                if (addr < reloc) continue;
                gap = addr - reloc;
                if (gap < res.distance) begin
                    res.distance   = gap;
                    res.best_index = i[INDEX_W-1:0];
                    res.found      = 1'b1;
                    if (gap == '0) break;
                end else if (gap == res.distance) begin
                    res.best_index = i[INDEX_W-1:0];
                    res.found      = 1'b1;
                end
            end
            return res;
        endfunction

        // The entry index is ten bits wide, so every write lands in the table.
        function void record_request(input t_lookup_req req);
            if (req.action == ACT_WRITE) begin
                sym_value[req.entry_index] = req.entry_value;
                sym_named[req.entry_index] = req.entry_named;
                writes_seen++;
            end else begin
                expected_lookups.push_back(nearest_symbol(req.query_address));
                queries_seen++;
            end
        endfunction

        function void compare_result(input t_lookup_resp got);
            t_lookup_resp exp_res;
            if (expected_lookups.size() == 0) begin
                $display("%0t: result with no query waiting: found %0b index %0d distance %h",
                         $time, got.found, got.best_index, got.distance);
                errors++;
                return;
            end
            exp_res = expected_lookups.pop_front();
            if (got.found) hits_seen++;
            if (got.found !== exp_res.found) begin
                $display("%0t: found mismatch: expected %0b, actual %0b",
                         $time, exp_res.found, got.found);
                errors++;
            end
            if (got.best_index !== exp_res.best_index) begin
                $display("%0t: best_index mismatch: expected %0d, actual %0d",
                         $time, exp_res.best_index, got.best_index);
                errors++;
            end
            if (got.distance !== exp_res.distance) begin
                $display("%0t: distance mismatch: expected %h, actual %h",
                         $time, exp_res.distance, got.distance);
                errors++;
            end
        endfunction

        function int pending();
            return expected_lookups.size();
        endfunction
    endclass

endpackage

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the nearest preceding symbol search core.
// ----------------------------------------------------------------------------
// A directed pass covers the empty table, unnamed entries, ties, exact hits
// and relocation that wraps. The low part of the table is then loaded, and
// four phases of random writes and queries follow under different idle and
// stall patterns, with the registers changed between rounds while the core
// is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import nps_pkg::*;
    import nps_check_pkg::*;

    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS    = 85;
    localparam int LOADED_ENTRIES = 200;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_index = CFG_BASE_ADDRESS;
    logic [VALUE_W-1:0] i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_action = ACT_WRITE;
    logic [INDEX_W-1:0] i_entry_index = '0;
    logic [VALUE_W-1:0] i_entry_value = '0;
    logic               i_entry_named = 1'b0;
    logic [VALUE_W-1:0] i_query_address = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_found;
    logic [INDEX_W-1:0] o_best_index;
    logic [VALUE_W-1:0] o_distance;

    lookup_scoreboard sb;
    int               send_idle = 0;
    int               stall_pct = 0;
    int               quiet_cycles = 0;

    nearest_preceding_symbol_search_core #(
        .TABLE_DEPTH(TB_TABLE_DEPTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_entry_index  (i_entry_index),
        .i_entry_value  (i_entry_value),
        .i_entry_named  (i_entry_named),
        .i_query_address(i_query_address),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_found        (o_found),
        .o_best_index   (o_best_index),
        .o_distance     (o_distance)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Result side: sample before the edge takes effect, then draw the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.compare_result('{found: o_found, best_index: o_best_index,
                                distance: o_distance});
        end
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic t_lookup_req make_write(input int idx, input logic [VALUE_W-1:0] val,
                                               input logic named);
        t_lookup_req req;
        req.action        = ACT_WRITE;
        req.entry_index   = idx[INDEX_W-1:0];
        req.entry_value   = val;
        req.entry_named   = named;
        req.query_address = $urandom;
        return req;
    endfunction

    function automatic t_lookup_req make_query(input logic [VALUE_W-1:0] addr);
        t_lookup_req req;
        req.action        = ACT_QUERY;
        req.entry_index   = INDEX_W'($urandom);
        req.entry_value   = $urandom;
        req.entry_named   = 1'($urandom_range(0, 1));
        req.query_address = addr;
        return req;
    endfunction

    // Most random traffic lands on or near relocated values already in the
    // searched range, so hits, ties and near misses come up often.
    function automatic t_lookup_req random_item(input int count);
        t_lookup_req        req;
        int                 span;
        int                 pick;
        int                 other;
        logic [VALUE_W-1:0] reloc;
        logic [VALUE_W-1:0] val;
        span  = (count < 1) ? 1 : ((count > TB_TABLE_DEPTH) ? TB_TABLE_DEPTH : count);
        pick  = $urandom_range(0, span - 1);
        other = $urandom_range(0, span - 1);
        reloc = sb.sym_value[pick] + sb.base_addr;
        req   = make_query(reloc);
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                case ($urandom_range(0, 3))
                    0:       val = sb.sym_value[other];
                    1:       val = sb.sym_value[other] + $urandom_range(1, 255);
                    2:       val = sb.sym_value[other] - $urandom_range(1, 255);
                    default: val = $urandom;
                endcase
                if ($urandom_range(0, 3) == 0) pick = $urandom_range(0, TB_TABLE_DEPTH - 1);
                req = make_write(pick, val, $urandom_range(0, 3) != 0);
            end
            3, 4:    req.query_address = reloc;
            5, 6:    req.query_address = reloc + $urandom_range(1, 300);
            7:       req.query_address = reloc - 1;
            8:       req.query_address = $urandom;
            default: req.query_address = $urandom_range(0, 1) ? '1 : '0;
        endcase
        return req;
    endfunction

    task automatic send_item(input t_lookup_req req);
        while ($urandom_range(0, 99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_action        <= req.action;
        i_entry_index   <= req.entry_index;
        i_entry_value   <= req.entry_value;
        i_entry_named   <= req.entry_named;
        i_query_address <= req.query_address;
        do @(posedge i_clk); while (o_in_stall);
        sb.record_request(req);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Leaves valid high; the caller lowers it after its last transaction.
    task automatic cfg_write(input logic idx, input logic [VALUE_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_config(idx, data);
    endtask

    task automatic reconfigure(input logic [VALUE_W-1:0] base, input int count);
        logic [VALUE_W-1:0] data;
        data = $urandom;
        data[COUNT_W-1:0] = count[COUNT_W-1:0];
        wait_drained();
        cfg_write(CFG_BASE_ADDRESS, base);
        cfg_write(CFG_SYMBOL_COUNT, data);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [VALUE_W-1:0] base;
        logic [VALUE_W-1:0] region;
        int                 count;
        int                 n_items;
        int                 items_left;
        int                 round;

        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Registers at their reset values: nothing is searched.
        send_item(make_query('1));
        send_item(make_query('0));

        // Ties at 0x180, an exact hit twice at 0x300, an unnamed entry between.
        send_item(make_write(0, 32'h0000_0100, 1'b1));
        send_item(make_write(1, 32'h0000_0200, 1'b0));
        send_item(make_write(2, 32'h0000_0180, 1'b1));
        send_item(make_write(3, 32'h0000_0180, 1'b1));
        send_item(make_write(4, 32'h0000_0300, 1'b1));
        send_item(make_write(5, 32'h0000_0300, 1'b1));
        send_item(make_write(6, 32'hFFFF_FFFF, 1'b1));
        send_item(make_write(7, 32'h0000_0000, 1'b1));
        reconfigure('0, 8);
        send_item(make_query(32'h0000_01C0));
        send_item(make_query(32'h0000_0300));
        send_item(make_query(32'h0000_0250));
        send_item(make_query(32'h0000_00FF));
        send_item(make_query('1));
        send_item(make_query('0));

        // Relocation that wraps past the top of the address space.
        reconfigure(32'hFFFF_FF00, 8);
        send_item(make_query(32'h0000_0010));
        send_item(make_query('1));
        send_item(make_query(32'hFFFF_FEFF));
        reconfigure('1, 1);
        send_item(make_query(32'h0000_00FF));
        send_item(make_query(32'h0000_00FE));
        reconfigure($urandom, 0);
        send_item(make_query($urandom));

        // Load the low slots so that any count up to that range is legal.
        region = $urandom;
        for (int i = 0; i < LOADED_ENTRIES; i++) begin
            send_item(make_write(i, ($urandom_range(0, 7) == 0) ? $urandom :
                                    region + $urandom_range(0, 32'h0003_FFFF),
                                 $urandom_range(0, 4) != 0));
        end

        for (int p = 0; p < 4; p++) begin
            case (p)
                0:       begin send_idle = 0;  stall_pct = 0;  end
                1:       begin send_idle = 86; stall_pct = 0;  end
                2:       begin send_idle = 0;  stall_pct = 86; end
                default: begin send_idle = 12; stall_pct = 12; end
            endcase
            items_left = PHASE_ITEMS;
            round = 0;
            while (items_left > 0) begin
                case ($urandom_range(0, 4))
                    0:       base = '0;
                    1:       base = '1;
                    2:       base = 32'h0 - sb.sym_value[$urandom_range(0, LOADED_ENTRIES - 1)];
                    default: base = $urandom;
                endcase
                // One round per phase searches the whole loaded range.
                if (round == 2) begin
                    count = LOADED_ENTRIES;
                    n_items = 5;
                end else begin
                    case ($urandom_range(0, 9))
                        0:       count = 0;
                        1:       count = 1;
                        9:       count = $urandom_range(49, LOADED_ENTRIES);
                        default: count = $urandom_range(2, 48);
                    endcase
                    n_items = $urandom_range(8, 20);
                end
                reconfigure(base, count);
                for (int k = 0; k < n_items; k++) send_item(random_item(count));
                items_left -= n_items;
                round++;
            end
        end

        wait_drained();
        $display("Ran %0d table writes and %0d queries, %0d of them matched,",
                 sb.writes_seen, sb.queries_seen, sb.hits_seen);
        $display("across four idle and stall patterns with the registers at their extremes.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
